@@ rtl/psu_pkg.sv @@
// shared types and constants for the png scanline unfilter
package psu_pkg;

   // default sizing
   localparam int DEF_MAX_ROW_BYTES   = 4096;
   localparam int DEF_MAX_PIXEL_BYTES = 8;

   // fixed field widths
   localparam int BYTE_W = 8;
   localparam int ROW_W  = 13;
   localparam int BPP_W  = 4;
   localparam int CSR_W  = 13;

   // highest valid filter type code
   localparam logic [BYTE_W-1:0] FILTER_MAX = 8'd4;

   // configuration register indexes
   typedef enum logic {
      CSR_ROW_BYTES       = 1'b0,
      CSR_BYTES_PER_PIXEL = 1'b1
   } csr_index_type;

   // row filter types
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // per-byte control passed from front to back
   typedef struct packed {
      logic       is_type;
      logic       bad;
      filter_type filter;
      logic       first_row;
      logic       last;
   } op_ctrl_type;

   localparam int OP_CTRL_W = $bits(op_ctrl_type);

endpackage

@@ rtl/psu_req_if.sv @@
// input channel: filtered byte stream
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_image;

   modport source (output valid, output data_byte, output start_image, input ready);
   modport sink   (input valid, input data_byte, input start_image, output ready);
endinterface

@@ rtl/psu_rsp_if.sv @@
// result channel: reconstructed byte stream
interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;
   logic       row_end;
   logic       bad_filter;

   modport source (output valid, output sample_byte, output row_end, output bad_filter,
                   input ready);
   modport sink   (input valid, input sample_byte, input row_end, input bad_filter,
                   output ready);
endinterface

@@ rtl/psu_front.sv @@
// front end: tracks row position and classifies each accepted byte
module psu_front #(
   parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int ADDR_W        = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [psu_pkg::ROW_W-1:0] row_bytes,
   psu_req_if.sink                   req_if,
   output logic                      push_valid,
   input  logic                      push_ready,
   output psu_pkg::op_ctrl_type      push_ctrl,
   output logic [psu_pkg::BYTE_W-1:0] push_byte,
   output logic [ADDR_W-1:0]         push_addr
);
   import psu_pkg::*;

   localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int CW    = (POS_W > ROW_W) ? POS_W : ROW_W;

   logic [POS_W-1:0] pos_ff, pos_in;
   filter_type       filter_ff, filter_in;
   logic             first_ff, first_in;

   logic [CW-1:0]    row_ext, max_ext, len_eff;
   logic [POS_W-1:0] cur_pos;
   logic             cur_first;
   logic             last;
   logic             bad;
   logic             accept;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign push_byte    = req_if.data_byte;

   // effective row length, clamped into range
   always_comb begin
      row_ext = CW'(row_bytes);
      max_ext = CW'(MAX_ROW_BYTES);
      if (row_ext == '0) begin
         len_eff = CW'(1);
      end else if (row_ext > max_ext) begin
         len_eff = max_ext;
      end else begin
         len_eff = row_ext;
      end
   end

   // classify the byte at the head of the input
   always_comb begin
      cur_pos   = req_if.start_image ? '0 : pos_ff;
      cur_first = req_if.start_image | first_ff;
      last      = (CW'(cur_pos) >= len_eff);
      bad       = (req_if.data_byte > FILTER_MAX);
      push_addr = ADDR_W'(cur_pos - POS_W'(1));

      push_ctrl.is_type   = (cur_pos == '0);
      push_ctrl.bad       = push_ctrl.is_type & bad;
      push_ctrl.filter    = filter_ff;
      push_ctrl.first_row = cur_first;
      push_ctrl.last      = last;

      pos_in    = pos_ff;
      filter_in = filter_ff;
      first_in  = first_ff;
      if (accept) begin
         if (cur_pos == '0) begin
            pos_in    = POS_W'(1);
            filter_in = bad ? FILT_NONE : filter_type'(req_if.data_byte[2:0]);
            first_in  = cur_first;
         end else if (last) begin
            pos_in   = '0;
            first_in = 1'b0;
         end else begin
            pos_in   = cur_pos + POS_W'(1);
            first_in = cur_first;
         end
      end
   end

   // row position state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filter_ff <= FILT_NONE;
         first_ff  <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         filter_ff <= filter_in;
         first_ff  <= first_in;
      end
   end

endmodule

@@ rtl/psu_op_queue.sv @@
// two-entry queue between front and back
module psu_op_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/psu_line_store.sv @@
// prior row line store, one write and one registered read per cycle
module psu_line_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/psu_back.sv @@
// back end: prior row fetch, byte reconstruction and result register
module psu_back #(
   parameter int MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
   parameter int ADDR_W          = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [psu_pkg::BPP_W-1:0]  bytes_per_pixel,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  psu_pkg::op_ctrl_type       pop_ctrl,
   input  logic [psu_pkg::BYTE_W-1:0] pop_byte,
   input  logic [ADDR_W-1:0]          pop_addr,
   psu_rsp_if.source                  rsp_if
);
   import psu_pkg::*;

   localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // execute stage
   logic              ex_valid_ff, ex_valid_in;
   op_ctrl_type       ex_ctrl_ff;
   logic [BYTE_W-1:0] ex_byte_ff;
   logic [ADDR_W-1:0] ex_addr_ff;

   // neighbor windows
   logic [BYTE_W-1:0] left_ff  [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0] upper_ff [MAX_PIXEL_BYTES];

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_sample_ff;
   logic              out_row_end_ff;
   logic              out_bad_ff;

   logic              out_free, fire, load, emit;
   logic [BYTE_W-1:0] prior_byte;
   logic [BPP_W-1:0]  bpp_eff;
   logic [IDX_W-1:0]  win_idx;
   logic [BYTE_W-1:0] a, b, c, pred, v;
   logic [8:0]        sum_ab, c_twice, pc;
   logic [7:0]        pa, pb;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign fire      = ex_valid_ff && out_free;
   assign pop_ready = !ex_valid_ff || fire;
   assign load      = pop_valid && pop_ready;
   assign emit      = fire && (!ex_ctrl_ff.is_type || ex_ctrl_ff.bad);

   psu_line_store #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (fire && !ex_ctrl_ff.is_type),
      .wr_addr (ex_addr_ff),
      .wr_data (v),
      .rd_en   (load),
      .rd_addr (pop_addr),
      .rd_data (prior_byte)
   );

   // filter distance, clamped into range
   always_comb begin
      if (bytes_per_pixel == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
         bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = bytes_per_pixel;
      end
      win_idx = IDX_W'(bpp_eff - BPP_W'(1));
   end

   // neighbors and reconstruction; windows are cleared at each row start
   always_comb begin
      a       = left_ff[win_idx];
      c       = upper_ff[win_idx];
      b       = ex_ctrl_ff.first_row ? '0 : prior_byte;
      sum_ab  = {1'b0, a} + {1'b0, b};
      c_twice = {c, 1'b0};
      pa      = (b >= c) ? (b - c) : (c - b);
      pb      = (a >= c) ? (a - c) : (c - a);
      pc      = (sum_ab >= c_twice) ? (sum_ab - c_twice) : (c_twice - sum_ab);
      unique case (ex_ctrl_ff.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = sum_ab[8:1];
         FILT_PAETH: begin
            if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
               pred = a;
            end else if ({1'b0, pb} <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = '0;
      endcase
      v = ex_byte_ff + pred;
   end

   // stage valid flags
   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (load) begin
         ex_valid_in = 1'b1;
      end else if (fire) begin
         ex_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // execute stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         ex_ctrl_ff <= pop_ctrl;
         ex_byte_ff <= pop_byte;
         ex_addr_ff <= pop_addr;
      end
   end

   // window update: clear on a type byte, shift in on a sample byte
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]  <= '0;
            upper_ff[i] <= '0;
         end
      end else if (fire) begin
         if (ex_ctrl_ff.is_type) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
               left_ff[i]  <= '0;
               upper_ff[i] <= '0;
            end
         end else begin
            left_ff[0]  <= v;
            upper_ff[0] <= b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
               left_ff[i]  <= left_ff[i-1];
               upper_ff[i] <= upper_ff[i-1];
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_sample_ff  <= ex_ctrl_ff.is_type ? '0 : v;
         out_row_end_ff <= !ex_ctrl_ff.is_type && ex_ctrl_ff.last;
         out_bad_ff     <= ex_ctrl_ff.is_type;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.sample_byte = out_sample_ff;
   assign rsp_if.row_end     = out_row_end_ff;
   assign rsp_if.bad_filter  = out_bad_ff;

endmodule

@@ rtl/png_scanline_unfilter.sv @@
// PNG scanline unfilter: rebuilds None/Sub/Up/Average/Paeth filtered rows from the
// inflated byte stream. The first byte of each row is its filter type and gives no
// transaction unless it is above four, in which case one transaction with bad_filter
// set comes out and the row passes through unfiltered. Throughput is one byte per
// clock sustained while rsp stays ready; a sample byte passes the queue, execute
// stage and result register. The back end sets the figure: it rebuilds one byte
// per cycle (a left neighbor may be the last result) and uses the line store's one
// read and one write port once per byte. A two-entry queue sits between front and
// back end, and the result register lets a new byte in while the last result
// waits. The user writes row_bytes and bytes_per_pixel through the csr port only
// while no transaction is in flight; the block does not enforce it.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   psu_req_if.sink                   req_if,
   psu_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  psu_pkg::csr_index_type    csr_index,
   input  logic [psu_pkg::CSR_W-1:0] csr_wdata
);
   import psu_pkg::*;

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int Q_W    = OP_CTRL_W + BYTE_W + ADDR_W;

   logic [ROW_W-1:0]  row_bytes_ff;
   logic [BPP_W-1:0]  bpp_ff;

   logic              push_valid, push_ready;
   op_ctrl_type       push_ctrl;
   logic [BYTE_W-1:0] push_byte;
   logic [ADDR_W-1:0] push_addr;

   logic              pop_valid, pop_ready;
   logic [Q_W-1:0]    pop_data;
   op_ctrl_type       pop_ctrl;
   logic [BYTE_W-1:0] pop_byte;
   logic [ADDR_W-1:0] pop_addr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_W'(1);
         bpp_ff       <= BPP_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_BYTES:       row_bytes_ff <= csr_wdata[ROW_W-1:0];
            CSR_BYTES_PER_PIXEL: bpp_ff       <= csr_wdata[BPP_W-1:0];
            default:             row_bytes_ff <= row_bytes_ff;
         endcase
      end
   end

   psu_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .ADDR_W        (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .row_bytes  (row_bytes_ff),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctrl  (push_ctrl),
      .push_byte  (push_byte),
      .push_addr  (push_addr)
   );

   psu_op_queue #(
      .WIDTH (Q_W)
   ) u_op_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_ctrl, push_byte, push_addr}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_ctrl, pop_byte, pop_addr} = pop_data;

   psu_back #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
      .ADDR_W          (ADDR_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .bytes_per_pixel (bpp_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_ctrl        (pop_ctrl),
      .pop_byte        (pop_byte),
      .pop_addr        (pop_addr),
      .rsp_if          (rsp_if)
   );

endmodule

@@ tb/png_scanline_unfilter_test.sv @@
// self-checking testbench for the png scanline unfilter
`timescale 1ns / 100ps

module png_scanline_unfilter_test;
   import psu_pkg::*;

   localparam int CYCLE_LIMIT  = 800_000;
   localparam int QUIET_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   // one byte of the filtered stream
   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_byte_type;

   // one rebuilt output transaction
   typedef struct packed {
      logic [7:0] sample;
      logic       row_end;
      logic       bad;
   } rebuilt_byte_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   psu_req_if req_ch ();
   psu_rsp_if rsp_ch ();

   png_scanline_unfilter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stream_byte_type  pending_bytes [$];
   rebuilt_byte_type rebuilt_expected [$];
   stream_byte_type  drive_byte;
   rebuilt_byte_type seen_byte;
   rebuilt_byte_type want_byte;

   int unsigned queued_count;
   int unsigned accepted_count;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   // shadow of the block: registers, prior row and neighbor history
   int unsigned shadow_row_len;
   int unsigned shadow_stride;
   logic [7:0]  above_line [DEF_MAX_ROW_BYTES];
   logic [7:0]  left_hist [DEF_MAX_PIXEL_BYTES];
   logic [7:0]  above_hist [DEF_MAX_PIXEL_BYTES];
   int unsigned row_pos;
   filter_type  row_kind;
   logic        top_row;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL png_scanline_unfilter");
         $finish;
      end
   end

   function automatic int unsigned active_row_len();
      if (shadow_row_len < 1) return 1;
      if (shadow_row_len > DEF_MAX_ROW_BYTES) return DEF_MAX_ROW_BYTES;
      return shadow_row_len;
   endfunction

   function automatic int unsigned active_stride();
      if (shadow_stride < 1) return 1;
      if (shadow_stride > DEF_MAX_PIXEL_BYTES) return DEF_MAX_PIXEL_BYTES;
      return shadow_stride;
   endfunction

   // paeth choice among left, above and upper-left
   function automatic int unsigned paeth_choose(int a, int b, int c);
      int pa;
      int pb;
      int pc;
      pa = (b >= c) ? b - c : c - b;
      pb = (a >= c) ? a - c : c - a;
      pc = (a + b >= 2 * c) ? a + b - 2 * c : 2 * c - a - b;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   // rebuild one accepted byte and queue the transaction it causes
   function automatic void unfilter_byte(logic [7:0] d, logic start);
      int unsigned len;
      int unsigned bpp;
      int unsigned p;
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned pred;
      logic [7:0]  v;
      logic        last;
      rebuilt_byte_type r;
      len = active_row_len();
      bpp = active_stride();
      if (start) begin
         top_row = 1'b1;
         row_pos = 0;
      end
      // type byte: clear history, only a bad type gives a transaction
      if (row_pos == 0) begin
         for (int i = 0; i < DEF_MAX_PIXEL_BYTES; i++) begin
            left_hist[i]  = 8'h00;
            above_hist[i] = 8'h00;
         end
         row_pos = 1;
         if (d > FILTER_MAX) begin
            row_kind   = FILT_NONE;
            r.sample   = 8'h00;
            r.row_end  = 1'b0;
            r.bad      = 1'b1;
            rebuilt_expected.insert(rebuilt_expected.size(), r);
         end else begin
            row_kind = filter_type'(d[2:0]);
         end
         return;
      end
      p = row_pos - 1;
      if (p >= DEF_MAX_ROW_BYTES) p = DEF_MAX_ROW_BYTES - 1;
      last = (p + 1 >= len);
      a = (p >= bpp) ? int'(left_hist[bpp-1]) : 0;
      b = top_row ? 0 : int'(above_line[p]);
      c = (p >= bpp) ? int'(above_hist[bpp-1]) : 0;
      case (row_kind)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = (a + b) >> 1;
         FILT_PAETH: pred = paeth_choose(a, b, c);
         default:    pred = 0;
      endcase
      v = d + 8'(pred);
      for (int i = DEF_MAX_PIXEL_BYTES - 1; i > 0; i--) begin
         left_hist[i]  = left_hist[i-1];
         above_hist[i] = above_hist[i-1];
      end
      left_hist[0]  = v;
      above_hist[0] = 8'(b);
      above_line[p] = v;
      if (last) begin
         row_pos = 0;
         top_row = 1'b0;
      end else begin
         row_pos = p + 2;
      end
      r.sample  = v;
      r.row_end = last;
      r.bad     = 1'b0;
      rebuilt_expected.insert(rebuilt_expected.size(), r);
   endfunction

   // stream driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            unfilter_byte(req_ch.data_byte, req_ch.start_image);
            accepted_count++;
         end
         if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_gap_pct) begin
            drive_byte = pending_bytes.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.data_byte   <= drive_byte.data;
            req_ch.start_image <= drive_byte.start;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   task automatic log_mismatch(string what, rebuilt_byte_type want, rebuilt_byte_type got);
      if (mismatch_count < REPORT_MAX)
         $display("%0t: %s: expected sample %02h row_end %0b bad %0b, got %02h %0b %0b",
                  $realtime, what, want.sample, want.row_end, want.bad,
                  got.sample, got.row_end, got.bad);
      mismatch_count++;
   endtask

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_byte.sample  = rsp_ch.sample_byte;
            seen_byte.row_end = rsp_ch.row_end;
            seen_byte.bad     = rsp_ch.bad_filter;
            if (rebuilt_expected.size() == 0) begin
               log_mismatch("unexpected transaction", '0, seen_byte);
            end else begin
               want_byte = rebuilt_expected.pop_front();
               if (seen_byte.sample !== want_byte.sample ||
                   seen_byte.row_end !== want_byte.row_end ||
                   seen_byte.bad !== want_byte.bad)
                  log_mismatch("wrong transaction", want_byte, seen_byte);
            end
         end
         rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   task automatic push_byte(logic [7:0] d, logic start);
      stream_byte_type item;
      item.data  = d;
      item.start = start;
      pending_bytes.insert(pending_bytes.size(), item);
      queued_count++;
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ROW_BYTES) shadow_row_len = value & 32'h1FFF;
      else shadow_stride = value & 32'hF;
   endtask

   // all bytes taken, all results in, and the pipe given time to settle
   task automatic wait_for_quiet();
      while (accepted_count != queued_count || rebuilt_expected.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // random stream of mostly well-formed rows, following the row position
   task automatic queue_rows(int unsigned count, bit noise, bit force_start);
      int unsigned pos;
      int unsigned len;
      logic [7:0]  d;
      logic        s;
      len = active_row_len();
      pos = row_pos;
      for (int k = 0; k < count; k++) begin
         s = 1'b0;
         if (k == 0 && force_start) s = 1'b1;
         else if (pos == 0 && $urandom_range(7, 0) == 0) s = 1'b1;
         else if (noise && $urandom_range(39, 0) == 0) s = 1'b1;
         if (s) pos = 0;
         if (pos == 0) begin
            if ($urandom_range(15, 0) == 0) d = 8'($urandom_range(255, 0));
            else d = 8'($urandom_range(int'(FILT_PAETH), int'(FILT_NONE)));
            pos = 1;
         end else begin
            case ($urandom_range(9, 0))
               0:       d = 8'h00;
               1:       d = 8'hFF;
               default: d = 8'($urandom_range(255, 0));
            endcase
            pos = (pos >= len) ? 0 : pos + 1;
         end
         push_byte(d, s);
      end
   endtask

   task automatic run_phase(int unsigned row_len, int unsigned stride, int unsigned count,
                            int unsigned gap_pct, int unsigned stall_pct, bit noise);
      int unsigned old_len;
      wait_for_quiet();
      old_len = active_row_len();
      write_csr(CSR_ROW_BYTES, row_len);
      write_csr(CSR_BYTES_PER_PIXEL, stride);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      // a longer row may only follow a new image, the prior row is too short
      queue_rows(count, noise, active_row_len() > old_len);
   endtask

   // main sequence
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_ROW_BYTES;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = 8'h00;
      req_ch.start_image = 1'b0;
      rsp_ch.ready       = 1'b0;
      queued_count       = 0;
      accepted_count     = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      send_gap_pct       = 0;
      recv_stall_pct     = 0;
      shadow_row_len     = 1;
      shadow_stride      = 1;
      row_pos            = 0;
      row_kind           = FILT_NONE;
      top_row            = 1'b1;
      for (int i = 0; i < DEF_MAX_ROW_BYTES; i++) above_line[i] = 8'h00;
      for (int i = 0; i < DEF_MAX_PIXEL_BYTES; i++) begin
         left_hist[i]  = 8'h00;
         above_hist[i] = 8'h00;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows of three bytes: every filter, extreme bytes, bad type, restart
      write_csr(CSR_ROW_BYTES, 3);
      write_csr(CSR_BYTES_PER_PIXEL, 1);
      push_byte(8'(FILT_NONE), 1'b1);
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'(FILT_SUB), 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h7F, 1'b0);
      push_byte(8'(FILT_UP), 1'b0);
      push_byte(8'h10, 1'b0); push_byte(8'hF0, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'(FILT_AVG), 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h81, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'(FILT_PAETH), 1'b0);
      push_byte(8'h05, 1'b0); push_byte(8'hFE, 1'b0); push_byte(8'h33, 1'b0);
      // bad type just above paeth, then a new image mid-row
      push_byte(FILTER_MAX + 8'd1, 1'b0);
      push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
      push_byte(8'(FILT_PAETH), 1'b1);
      push_byte(8'hAA, 1'b0);

      // random phases over sizes, strides and idling patterns
      run_phase(4, 1, 150, 0, 0, 1'b1);
      run_phase(12, 3, 150, 61, 0, 1'b1);
      run_phase(1, 8, 120, 0, 61, 1'b1);
      run_phase(24, 4, 150, 26, 26, 1'b1);
      run_phase(0, 0, 80, 61, 0, 1'b1);
      run_phase(37, 15, 150, 0, 0, 1'b1);
      // a long stretch at the largest size, then a size above it
      run_phase(DEF_MAX_ROW_BYTES, 6, 120, 0, 0, 1'b0);
      run_phase(8191, 2, 100, 0, 0, 1'b0);
      // shrinking in mid-row ends the row on the next byte
      run_phase(16, 7, 150, 61, 0, 1'b1);
      run_phase(9, 5, 150, 0, 61, 1'b1);
      run_phase(2, 2, 140, 26, 26, 1'b1);
      run_phase(30, 8, 150, 61, 0, 1'b1);
      run_phase(5, 1, 120, 0, 0, 1'b1);
      wait_for_quiet();

      if (mismatch_count == 0) begin
         $display("PASS png_scanline_unfilter");
      end else begin
         $display("FAIL png_scanline_unfilter");
      end
      $finish;
   end

endmodule
